// ----- rtl/core/rrht_pkg.sv -----
package rrht_pkg;

  // Configuration register index width (leaves room for unused indexes)
  localparam int unsigned CfgIdxW = 3;

  // Register stages from input acceptance to the result register
  localparam int unsigned NumStages = 7;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    RegLeft   = 3'd0,
    RegRight  = 3'd1,
    RegTop    = 3'd2,
    RegBottom = 3'd3
  } rrht_reg_e;

endpackage

// ----- rtl/core/rrht_in_if.sv -----
interface rrht_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-2:0] radius_x_top_left;
  logic [COORD_BITS-2:0] radius_x_top_right;
  logic [COORD_BITS-2:0] radius_x_bottom_right;
  logic [COORD_BITS-2:0] radius_x_bottom_left;
  logic [COORD_BITS-2:0] radius_y_top_left;
  logic [COORD_BITS-2:0] radius_y_top_right;
  logic [COORD_BITS-2:0] radius_y_bottom_right;
  logic [COORD_BITS-2:0] radius_y_bottom_left;

  modport source (
    output valid, point_x, point_y,
    output radius_x_top_left, radius_x_top_right, radius_x_bottom_right, radius_x_bottom_left,
    output radius_y_top_left, radius_y_top_right, radius_y_bottom_right, radius_y_bottom_left,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y,
    input  radius_x_top_left, radius_x_top_right, radius_x_bottom_right, radius_x_bottom_left,
    input  radius_y_top_left, radius_y_top_right, radius_y_bottom_right, radius_y_bottom_left,
    output ready
  );
endinterface

// ----- rtl/core/rrht_out_if.sv -----
interface rrht_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

// ----- rtl/core/rounded_rect_hit_test_top.sv -----
// Channel | Dir | Handshake         | Payload
// pt_i    | in  | valid/ready       | point_x, point_y, radius_x_*, radius_y_* (4 corners)
// res_o   | out | valid/ready       | inside_res
// cfg     | in  | cfg_we_i, no wait | cfg_idx_i, cfg_data_i (rect_left/right/top/bottom)
//
// One item per cycle unless res_o stalls; a result reaches res_o from the stage 7 register.
// The seven stages: bounds, corner pick, radius products, split squaring
// (three half-width partial products per square), square assembly, sum, compare.
// Reset clears the stage valid bits and the left, right, top and bottom edge registers to zero.
// A stalled output holds full stages only; empty stages keep filling, so up to
// seven items may be in flight while res_o waits.
module rounded_rect_hit_test_top
  import rrht_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rrht_in_if.sink               pt_i,
  rrht_out_if.source            res_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned RW = COORD_BITS - 1;
  localparam int unsigned PW = 2 * RW;
  localparam int unsigned SW = 4 * RW;

  // Rectangle edge registers
  logic [CW-1:0] left_q, right_q, top_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      top_q    <= '0;
      bottom_q <= '0;
    end else if (cfg_we_i) begin
      case (rrht_reg_e'(cfg_idx_i))
        RegLeft:   left_q   <= cfg_data_i;
        RegRight:  right_q  <= cfg_data_i;
        RegTop:    top_q    <= cfg_data_i;
        RegBottom: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NumStages:1] vld_q;
  logic [NumStages:1] adv;

  always_comb begin
    adv[NumStages] = !vld_q[NumStages] || res_o.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) begin
        vld_q[1] <= pt_i.valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign pt_i.ready       = adv[1];
  assign res_o.valid      = vld_q[NumStages];

  // Stage 1: offsets from the rectangle origin and bounds check
  logic signed [CW:0] px_e, py_e, l_e, r_e, t_e, b_e;
  logic signed [CW:0] x_d, y_d, xr_d, yb_d, w_d, h_d;
  logic signed [CW:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic               s1_in_q;
  logic [RW-1:0]      s1_rx_q [4];
  logic [RW-1:0]      s1_ry_q [4];

  always_comb begin
    px_e = $signed({pt_i.point_x[CW-1], pt_i.point_x});
    py_e = $signed({pt_i.point_y[CW-1], pt_i.point_y});
    l_e  = $signed({left_q[CW-1], left_q});
    r_e  = $signed({right_q[CW-1], right_q});
    t_e  = $signed({top_q[CW-1], top_q});
    b_e  = $signed({bottom_q[CW-1], bottom_q});
    x_d  = px_e - l_e;
    y_d  = py_e - t_e;
    xr_d = r_e - px_e;
    yb_d = b_e - py_e;
    w_d  = r_e - l_e;
    h_d  = b_e - t_e;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_x_q     <= x_d;
      s1_y_q     <= y_d;
      s1_w_q     <= w_d;
      s1_h_q     <= h_d;
      s1_in_q    <= !x_d[CW] && !y_d[CW] && !xr_d[CW] && !yb_d[CW];
      s1_rx_q[0] <= pt_i.radius_x_top_left;
      s1_rx_q[1] <= pt_i.radius_x_top_right;
      s1_rx_q[2] <= pt_i.radius_x_bottom_right;
      s1_rx_q[3] <= pt_i.radius_x_bottom_left;
      s1_ry_q[0] <= pt_i.radius_y_top_left;
      s1_ry_q[1] <= pt_i.radius_y_top_right;
      s1_ry_q[2] <= pt_i.radius_y_bottom_right;
      s1_ry_q[3] <= pt_i.radius_y_bottom_left;
    end
  end

  // Stage 2: corner region tests in priority order, pick distances and radii
  function automatic logic is_pos(input logic signed [CW+1:0] v);
    return !v[CW+1] && (v != '0);
  endfunction

  logic signed [CW+1:0] xe, ye, we, he;
  logic signed [CW+1:0] tl_dx, tl_dy, tr_dx, tr_dy, br_dx, br_dy, bl_dx, bl_dy;
  logic                 hit_tl, hit_tr, hit_br, hit_bl;
  logic [RW-1:0]        ax_d, ay_d, rx_d, ry_d;
  logic                 s2_need_q, s2_base_q;
  logic [RW-1:0]        s2_ax_q, s2_ay_q, s2_rx_q, s2_ry_q;

  always_comb begin
    xe    = {s1_x_q[CW], s1_x_q};
    ye    = {s1_y_q[CW], s1_y_q};
    we    = {s1_w_q[CW], s1_w_q};
    he    = {s1_h_q[CW], s1_h_q};
    tl_dx = $signed({3'b000, s1_rx_q[0]}) - xe;
    tl_dy = $signed({3'b000, s1_ry_q[0]}) - ye;
    tr_dx = xe - we + $signed({3'b000, s1_rx_q[1]});
    tr_dy = $signed({3'b000, s1_ry_q[1]}) - ye;
    br_dx = xe - we + $signed({3'b000, s1_rx_q[2]});
    br_dy = ye - he + $signed({3'b000, s1_ry_q[2]});
    bl_dx = $signed({3'b000, s1_rx_q[3]}) - xe;
    bl_dy = ye - he + $signed({3'b000, s1_ry_q[3]});
    hit_tl = is_pos(tl_dx) && is_pos(tl_dy);
    hit_tr = is_pos(tr_dx) && is_pos(tr_dy);
    hit_br = is_pos(br_dx) && is_pos(br_dy);
    hit_bl = is_pos(bl_dx) && is_pos(bl_dy);
  end

  always_comb begin
    ax_d = tl_dx[RW-1:0];
    ay_d = tl_dy[RW-1:0];
    rx_d = s1_rx_q[0];
    ry_d = s1_ry_q[0];
    if (hit_tl) begin
      ax_d = tl_dx[RW-1:0];
      ay_d = tl_dy[RW-1:0];
      rx_d = s1_rx_q[0];
      ry_d = s1_ry_q[0];
    end else if (hit_tr) begin
      ax_d = tr_dx[RW-1:0];
      ay_d = tr_dy[RW-1:0];
      rx_d = s1_rx_q[1];
      ry_d = s1_ry_q[1];
    end else if (hit_br) begin
      ax_d = br_dx[RW-1:0];
      ay_d = br_dy[RW-1:0];
      rx_d = s1_rx_q[2];
      ry_d = s1_ry_q[2];
    end else if (hit_bl) begin
      ax_d = bl_dx[RW-1:0];
      ay_d = bl_dy[RW-1:0];
      rx_d = s1_rx_q[3];
      ry_d = s1_ry_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_need_q <= s1_in_q && (hit_tl || hit_tr || hit_br || hit_bl);
      s2_base_q <= s1_in_q;
      s2_ax_q   <= ax_d;
      s2_ay_q   <= ay_d;
      s2_rx_q   <= rx_d;
      s2_ry_q   <= ry_d;
    end
  end

  // Stage 3: p = ax*ry, q = ay*rx, c = rx*ry
  logic [PW-1:0] s3_m_q [3];
  logic          s3_need_q, s3_base_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_m_q[0] <= PW'(s2_ax_q) * PW'(s2_ry_q);
      s3_m_q[1] <= PW'(s2_ay_q) * PW'(s2_rx_q);
      s3_m_q[2] <= PW'(s2_rx_q) * PW'(s2_ry_q);
      s3_need_q <= s2_need_q;
      s3_base_q <= s2_base_q;
    end
  end

  // Stage 4: half-width partial products of each square
  logic [PW-1:0] s4_hh_q [3];
  logic [PW-1:0] s4_hl_q [3];
  logic [PW-1:0] s4_ll_q [3];
  logic          s4_need_q, s4_base_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_hh_q[i] <= PW'(s3_m_q[i][PW-1:RW]) * PW'(s3_m_q[i][PW-1:RW]);
        s4_hl_q[i] <= PW'(s3_m_q[i][PW-1:RW]) * PW'(s3_m_q[i][RW-1:0]);
        s4_ll_q[i] <= PW'(s3_m_q[i][RW-1:0]) * PW'(s3_m_q[i][RW-1:0]);
      end
      s4_need_q <= s3_need_q;
      s4_base_q <= s3_base_q;
    end
  end

  // Stage 5: assemble the three squares
  logic [SW-1:0] s5_sq_q [3];
  logic          s5_need_q, s5_base_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq_q[i] <= (SW'(s4_hh_q[i]) << PW) + (SW'(s4_hl_q[i]) << (RW + 1))
                      + SW'(s4_ll_q[i]);
      end
      s5_need_q <= s4_need_q;
      s5_base_q <= s4_base_q;
    end
  end

  // Stage 6: left-hand sum of the ellipse test
  logic [SW:0]   s6_sum_q;
  logic [SW-1:0] s6_c2_q;
  logic          s6_need_q, s6_base_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_sum_q  <= {1'b0, s5_sq_q[0]} + {1'b0, s5_sq_q[1]};
      s6_c2_q   <= s5_sq_q[2];
      s6_need_q <= s5_need_q;
      s6_base_q <= s5_base_q;
    end
  end

  // Stage 7: compare and hold the result for the output
  logic s7_res_q;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_res_q <= s6_need_q ? (s6_sum_q <= {1'b0, s6_c2_q}) : s6_base_q;
    end
  end

  assign res_o.inside_res = s7_res_q;

endmodule

// ----- rtl/core/rrht_checker.sv -----
module rrht_checker
  import rrht_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_res_i
);

  localparam int unsigned OccW = $clog2(NumStages + 2);

  logic [OccW-1:0] occ_q, occ_d;
  logic            in_acc, out_acc;

  // Track items in flight
  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + OccW'(1);
    end else if (out_acc && !in_acc) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Hold a waiting result unchanged
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_res_i))
    else $error("result dropped or changed while stalled");

  // Drop no result from nowhere
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != '0)
    else $error("result without an accepted item");

  // Bound items in flight by the pipeline depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(NumStages))
    else $error("more items in flight than stages");

  // Refuse input only when the output is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind rounded_rect_hit_test_top rrht_checker u_rrht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_res_i   (res_o.inside_res)
);

// ----- verif/rounded_rect_hit_test_top_tb.sv -----
module rounded_rect_hit_test_top_tb;
  import rrht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 16;
  localparam longint CoordMin = -(64'sd1 <<< (CB - 1));
  localparam longint CoordMax = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint RadMax = (64'sd1 <<< (CB - 1)) - 1;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned StallLimit = 1000;

  // Rectangle used by the directed items, with 4 fraction bits: x in [-10, 20], y in [-5, 15]
  localparam longint StdLeft = -160;
  localparam longint StdRight = 320;
  localparam longint StdTop = -80;
  localparam longint StdBottom = 240;

  typedef enum int {CornerTl, CornerTr, CornerBr, CornerBl} corner_e;

  typedef struct packed {
    logic [CB-1:0]          px;
    logic [CB-1:0]          py;
    logic [3:0][CB-2:0]     rx;
    logic [3:0][CB-2:0]     ry;
  } pt_item_t;

  typedef struct {
    bit       hit;
    pt_item_t src;
  } hit_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Values driven into the block, all known from time zero
  logic                src_valid = 1'b0;
  pt_item_t            src_item = '0;
  logic                sink_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = RegLeft;
  logic [CB-1:0]       cfg_data = '0;

  logic        pt_taken = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned src_idle_odds = 0;
  int unsigned sink_idle_odds = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Edge registers as the block should hold them
  logic signed [CB-1:0] rect_left = '0;
  logic signed [CB-1:0] rect_right = '0;
  logic signed [CB-1:0] rect_top = '0;
  logic signed [CB-1:0] rect_bottom = '0;

  pt_item_t pending_pts[$];
  hit_exp_t expected_hits[$];

  rrht_in_if #(.COORD_BITS(CB)) pt_if ();
  rrht_out_if res_if ();

  assign pt_if.valid                 = src_valid;
  assign pt_if.point_x               = src_item.px;
  assign pt_if.point_y               = src_item.py;
  assign pt_if.radius_x_top_left     = src_item.rx[CornerTl];
  assign pt_if.radius_x_top_right    = src_item.rx[CornerTr];
  assign pt_if.radius_x_bottom_right = src_item.rx[CornerBr];
  assign pt_if.radius_x_bottom_left  = src_item.rx[CornerBl];
  assign pt_if.radius_y_top_left     = src_item.ry[CornerTl];
  assign pt_if.radius_y_top_right    = src_item.ry[CornerTr];
  assign pt_if.radius_y_bottom_right = src_item.ry[CornerBr];
  assign pt_if.radius_y_bottom_left  = src_item.ry[CornerBl];
  assign res_if.ready                = sink_ready;

  rounded_rect_hit_test_top #(
    .COORD_BITS(CB)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_i      (pt_if),
    .res_o     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Exact ellipse membership, boundary counts as a hit
  function automatic bit ellipse_holds(longint dx, longint dy, longint rx, longint ry);
    logic [63:0]  ax;
    logic [63:0]  ay;
    logic [63:0]  p;
    logic [63:0]  q;
    logic [63:0]  c;
    logic [129:0] lhs;
    logic [129:0] rhs;
    if (rx == 0 || ry == 0) return 1'b1;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    p = ax * 64'(ry);
    q = ay * 64'(rx);
    c = 64'(rx) * 64'(ry);
    lhs = 130'(p) * 130'(p) + 130'(q) * 130'(q);
    rhs = 130'(c) * 130'(c);
    return lhs <= rhs;
  endfunction

  // Point-in-rounded-rectangle against the current edge registers
  function automatic bit predict_hit(pt_item_t it);
    longint px, py, l, r, t, b, w, h, x, y;
    longint rx[4];
    longint ry[4];
    px = longint'($signed(it.px));
    py = longint'($signed(it.py));
    l = longint'(rect_left);
    r = longint'(rect_right);
    t = longint'(rect_top);
    b = longint'(rect_bottom);
    for (int k = 0; k < 4; k++) begin
      rx[k] = longint'(it.rx[k]);
      ry[k] = longint'(it.ry[k]);
    end
    if (px < l || px > r || py < t || py > b) return 1'b0;
    w = r - l;
    h = b - t;
    x = px - l;
    y = py - t;
    // First corner region holding the point decides
    if (x < rx[CornerTl] && y < ry[CornerTl])
      return ellipse_holds(x - rx[CornerTl], y - ry[CornerTl], rx[CornerTl], ry[CornerTl]);
    if (x > w - rx[CornerTr] && y < ry[CornerTr])
      return ellipse_holds(x - (w - rx[CornerTr]), y - ry[CornerTr],
                           rx[CornerTr], ry[CornerTr]);
    if (x > w - rx[CornerBr] && y > h - ry[CornerBr])
      return ellipse_holds(x - (w - rx[CornerBr]), y - (h - ry[CornerBr]),
                           rx[CornerBr], ry[CornerBr]);
    if (x < rx[CornerBl] && y > h - ry[CornerBl])
      return ellipse_holds(x - rx[CornerBl], y - (h - ry[CornerBl]),
                           rx[CornerBl], ry[CornerBl]);
    return 1'b1;
  endfunction

  function automatic logic [CB-1:0] to_coord(longint v);
    if (v < CoordMin) v = CoordMin;
    if (v > CoordMax) v = CoordMax;
    return CB'(v);
  endfunction

  function automatic longint rand_coord();
    return longint'($signed(CB'($urandom)));
  endfunction

  function automatic pt_item_t pt_at(longint x, longint y, longint rad_x, longint rad_y);
    pt_item_t it;
    it.px = to_coord(x);
    it.py = to_coord(y);
    for (int k = 0; k < 4; k++) begin
      it.rx[k] = (CB-1)'(rad_x);
      it.ry[k] = (CB-1)'(rad_y);
    end
    return it;
  endfunction

  // Radius scaled to the side length, with zero, full-scale and unbounded random picks mixed in
  function automatic logic [CB-2:0] pick_radius(longint span);
    longint cap;
    cap = (span > RadMax) ? RadMax : ((span < 0) ? 0 : span);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return (CB-1)'(RadMax);
      2: return (CB-1)'($urandom);
      3: return (CB-1)'($urandom_range(0, int'(cap / 8)));
      4: return (CB-1)'($urandom_range(0, int'(cap)));
      default: return (CB-1)'($urandom_range(0, int'(cap / 2)));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Write one register and track it in the predictor's copy
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CB-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      RegLeft:   rect_left = data;
      RegRight:  rect_right = data;
      RegTop:    rect_top = data;
      RegBottom: rect_bottom = data;
      default: ;
    endcase
  endtask

  task automatic set_rect(longint l, longint r, longint t, longint b);
    write_reg(RegLeft, CB'(l));
    write_reg(RegRight, CB'(r));
    write_reg(RegTop, CB'(t));
    write_reg(RegBottom, CB'(b));
    // Writes to unmapped indexes must leave the edges alone
    if ($urandom_range(0, 1) == 0)
      write_reg(CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1)), CB'($urandom));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item has gone through and the pipeline has settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_pts.size() != 0 || src_valid || expected_hits.size() != 0);
    repeat (NumStages + 4) @(negedge clk_i);
  endtask

  // Mostly points near the corner ellipses, some uniform, some pure noise
  task automatic push_random_pts(int unsigned n);
    pt_item_t it;
    longint   l, r, t, b, wspan, hspan, ox, oy;
    corner_e  k;
    for (int unsigned i = 0; i < n; i++) begin
      l = longint'(rect_left);
      r = longint'(rect_right);
      t = longint'(rect_top);
      b = longint'(rect_bottom);
      wspan = (r > l) ? r - l : 0;
      hspan = (b > t) ? b - t : 0;
      for (int c = 0; c < 4; c++) begin
        it.rx[c] = pick_radius(wspan);
        it.ry[c] = pick_radius(hspan);
      end
      case ($urandom_range(0, 9))
        0: begin
          it.px = CB'($urandom);
          it.py = CB'($urandom);
          for (int c = 0; c < 4; c++) begin
            it.rx[c] = (CB-1)'($urandom);
            it.ry[c] = (CB-1)'($urandom);
          end
        end
        1, 2, 3: begin
          it.px = to_coord(l - 2 + $urandom_range(0, int'(wspan + 4)));
          it.py = to_coord(t - 2 + $urandom_range(0, int'(hspan + 4)));
        end
        default: begin
          k = corner_e'($urandom_range(0, 3));
          ox = $urandom_range(0, int'(it.rx[k]) + 2);
          oy = $urandom_range(0, int'(it.ry[k]) + 2);
          it.px = to_coord((k == CornerTl || k == CornerBl) ? l + ox : r - ox);
          it.py = to_coord((k == CornerTl || k == CornerTr) ? t + oy : b - oy);
        end
      endcase
      pending_pts.push_back(it);
    end
  endtask

  // Source side: present the next item once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!src_valid || pt_taken) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          src_valid <= 1'b0;
        end else if (pending_pts.size() != 0 && src_idle_odds != 0 &&
                     $urandom_range(1, 100) <= src_idle_odds) begin
          src_gap <= $urandom_range(0, 5);
          src_valid <= 1'b0;
        end else if (pending_pts.size() != 0) begin
          src_item <= pending_pts.pop_front();
          src_valid <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: ready with random stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        sink_ready <= 1'b0;
      end else if (sink_idle_odds != 0 && $urandom_range(1, 100) <= sink_idle_odds) begin
        sink_gap <= $urandom_range(0, 5);
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Check results in order, then record the expectation for a new item
  always @(posedge clk_i) begin
    hit_exp_t exp_hit;
    if (rst_ni) begin
      pt_taken <= src_valid && pt_if.ready;
      if (res_if.valid && sink_ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result inside_res=%0b with no item outstanding",
                                    res_if.inside_res));
        end else begin
          exp_hit = expected_hits.pop_front();
          if (res_if.inside_res !== exp_hit.hit)
            report_mismatch($sformatf(
              "inside_res %b, want %0b, point (%0d,%0d) rect x[%0d,%0d] y[%0d,%0d]",
              res_if.inside_res, exp_hit.hit, $signed(exp_hit.src.px),
              $signed(exp_hit.src.py), rect_left, rect_right, rect_top, rect_bottom));
        end
      end
      if (src_valid && pt_if.ready) begin
        exp_hit.hit = predict_hit(src_item);
        exp_hit.src = src_item;
        expected_hits.push_back(exp_hit);
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk_i) begin
    if ((src_valid && pt_if.ready) || (res_if.valid && sink_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no item moved for %0d cycles", StallLimit);
      $display("** rounded_rect_hit_test_top: FAILED **");
      $finish;
    end
  end

  initial begin
    pt_item_t it;
    longint   a, c, l, t;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset edges: the rectangle is the single point at the origin
    src_idle_odds = 20;
    sink_idle_odds = 20;
    pending_pts.push_back(pt_at(0, 0, 0, 0));
    pending_pts.push_back(pt_at(0, 0, 16, 16));
    pending_pts.push_back(pt_at(1, 0, 0, 0));
    push_random_pts(30);
    wait_idle();

    // Directed points against a mid-size rectangle with 5.0 corner radii
    set_rect(StdLeft, StdRight, StdTop, StdBottom);
    pending_pts.push_back(pt_at(StdLeft - 1, 0, 80, 80));
    pending_pts.push_back(pt_at(StdRight + 1, 0, 80, 80));
    pending_pts.push_back(pt_at(0, StdTop - 1, 80, 80));
    pending_pts.push_back(pt_at(0, StdBottom + 1, 80, 80));
    pending_pts.push_back(pt_at(StdLeft, StdTop, 0, 0));
    pending_pts.push_back(pt_at(StdRight, StdBottom, 0, 0));
    pending_pts.push_back(pt_at(StdLeft, StdTop, 80, 80));
    // On the ellipse (3-4-5 offsets) and one step outside, every corner
    pending_pts.push_back(pt_at(StdLeft + 32, StdTop + 16, 80, 80));
    pending_pts.push_back(pt_at(StdLeft + 32, StdTop + 15, 80, 80));
    pending_pts.push_back(pt_at(StdRight - 32, StdTop + 16, 80, 80));
    pending_pts.push_back(pt_at(StdRight - 32, StdTop + 15, 80, 80));
    pending_pts.push_back(pt_at(StdRight - 32, StdBottom - 16, 80, 80));
    pending_pts.push_back(pt_at(StdRight - 32, StdBottom - 15, 80, 80));
    pending_pts.push_back(pt_at(StdLeft + 32, StdBottom - 16, 80, 80));
    pending_pts.push_back(pt_at(StdLeft + 32, StdBottom - 15, 80, 80));
    pending_pts.push_back(pt_at(StdLeft + 240, StdTop + 160, 80, 80));
    // Square top-left corner from a zero horizontal radius alone
    it = pt_at(StdLeft, StdTop, 80, 80);
    it.rx[CornerTl] = '0;
    pending_pts.push_back(it);
    // Radii far beyond the rectangle: top-left covers everything
    pending_pts.push_back(pt_at(StdLeft + 240, StdTop + 160, RadMax, RadMax));
    // Overlapping top corners, top-left wins
    it = pt_at(StdLeft + 240, StdTop + 10, 80, 80);
    it.rx[CornerTl] = 400;
    it.ry[CornerTl] = 300;
    it.rx[CornerTr] = 400;
    it.ry[CornerTr] = 300;
    pending_pts.push_back(it);
    pending_pts.push_back(pt_at(CoordMin, CoordMax, RadMax, RadMax));
    pending_pts.push_back(pt_at(CoordMax, CoordMin, RadMax, RadMax));
    push_random_pts(300);
    wait_idle();

    // Full coordinate range
    src_idle_odds = 30;
    sink_idle_odds = 10;
    set_rect(CoordMin, CoordMax, CoordMin, CoordMax);
    pending_pts.push_back(pt_at(CoordMin, CoordMin, 0, 0));
    pending_pts.push_back(pt_at(CoordMax, CoordMax, 0, 0));
    pending_pts.push_back(pt_at(CoordMin, CoordMin, RadMax, RadMax));
    push_random_pts(250);
    wait_idle();

    // Inverted in x, then in y: nothing can hit
    src_idle_odds = 10;
    sink_idle_odds = 40;
    set_rect(100, -100, -50, 50);
    pending_pts.push_back(pt_at(0, 0, 0, 0));
    push_random_pts(60);
    wait_idle();
    set_rect(-100, 100, 50, -50);
    pending_pts.push_back(pt_at(0, 0, 0, 0));
    push_random_pts(60);
    wait_idle();

    // Zero-width rectangle
    set_rect(32, 32, -400, 400);
    push_random_pts(60);
    wait_idle();

    // Random rectangles under varying pressure, some with no idling at all
    for (int p = 0; p < 8; p++) begin
      src_idle_odds = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
      sink_idle_odds = (p % 4 == 1) ? 0 : $urandom_range(5, 50);
      case ($urandom_range(0, 3))
        0: set_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        1: begin
          l = rand_coord() % 32000;
          t = rand_coord() % 32000;
          set_rect(l, l + $urandom_range(0, 64), t, t + $urandom_range(0, 64));
        end
        default: begin
          a = rand_coord();
          c = rand_coord();
          l = rand_coord();
          t = rand_coord();
          set_rect((a < c) ? a : c, (a < c) ? c : a, (l < t) ? l : t, (l < t) ? t : l);
        end
      endcase
      push_random_pts(100);
      wait_idle();
    end

    // Closing stretch at full rate on both sides
    src_idle_odds = 0;
    sink_idle_odds = 0;
    l = rand_coord() % 16000;
    t = rand_coord() % 16000;
    set_rect(l, l + $urandom_range(0, 8000), t, t + $urandom_range(0, 8000));
    push_random_pts(200);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("** rounded_rect_hit_test_top: PASSED **");
    end else begin
      $display("** rounded_rect_hit_test_top: FAILED **");
    end
    $finish;
  end

endmodule
